// ===== hw/rtl/lfhrp_pkg.sv =====
// Shared types, constants and the header table of the LED frame report packer.
// No dependencies; the controller, datapath and top level import this package.
package lfhrp_pkg;

  localparam int MAX_REPORT_BYTES = 64;
  localparam int RESULT_CAP       = 64;
  localparam int LEN_CAP = (MAX_REPORT_BYTES < RESULT_CAP) ? MAX_REPORT_BYTES : RESULT_CAP;

  localparam logic [6:0] RLEN_RESET = 7'd64;
  localparam logic [6:0] RLEN_MIN   = 7'd2;
  localparam logic [6:0] RLEN_MAX   = 7'(LEN_CAP);

  localparam logic [2:0] LAST_STEP  = 3'd4;
  localparam logic [7:0] REC_MARK   = 8'h80;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_HDR  = 2'd1,
    SEL_REC  = 2'd2
  } sel_e;

  typedef struct packed {
    logic       item_ready;
    logic       load_item;
    logic       emit;
    logic       push;
    sel_e       sel;
    logic [2:0] step;
    logic       last;
    logic       hdr_set;
    logic       led_inc;
    logic       clear_frame;
  } cmd_t;

  typedef struct packed {
    logic item_valid;
    logic item_action;
    logic hdr_done;
    logic fill_zero;
    logic close;
    logic out_free;
  } status_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h53;
      3'd1:    b = 8'h43;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h01;
      3'd4:    b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/lfhrp_if.sv =====
// Channel interfaces of the LED frame report packer: input item, result byte
// and configuration write. No dependencies.
interface lfhrp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, action, red, green, blue, input ready);
  modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface lfhrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       report_end;
  logic       run_last;
  modport source (output valid, out_byte, report_end, run_last, input ready);
  modport sink   (input valid, out_byte, report_end, run_last, output ready);
endinterface

interface lfhrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] report_length;
  modport source (output valid, report_length, input ready);
  modport sink   (input valid, report_length, output ready);
endinterface

// ===== hw/rtl/lfhrp_ctrl.sv =====
// Controller of the LED frame report packer: sequences report ID, header, record and
// padding bytes one per cycle while the output register can take a byte. Depends on lfhrp_pkg.
module lfhrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfhrp_pkg::status_t status_i,
  output lfhrp_pkg::cmd_t    cmd_o
);
  import lfhrp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_REC  = 2'd2;
  localparam logic [1:0] S_PAD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       id_q, id_d;
  logic       action_q, action_d;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    step_d   = step_q;
    id_d     = id_q;
    action_d = action_q;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.item_ready = 1'b1;
        if (status_i.item_valid) begin
          cmd_o.load_item = 1'b1;
          action_d = status_i.item_action;
          step_d   = 3'd0;
          id_d     = 1'b0;
          if (!status_i.hdr_done) begin
            state_d = S_HDR;
          end else if (status_i.item_action) begin
            state_d = S_PAD;
          end else begin
            state_d = S_REC;
          end
        end
      end
      S_HDR, S_REC, S_PAD: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.fill_zero && !id_q) begin
            cmd_o.sel = SEL_ZERO;
            id_d = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
            id_d = 1'b0;
            case (state_q)
              S_HDR: begin
                cmd_o.sel = SEL_HDR;
                step_d = step_q + 3'd1;
                if (step_q == LAST_STEP) begin
                  cmd_o.hdr_set = 1'b1;
                  step_d  = 3'd0;
                  state_d = action_q ? S_PAD : S_REC;
                end
              end
              S_REC: begin
                cmd_o.sel = SEL_REC;
                step_d = step_q + 3'd1;
                if (step_q == LAST_STEP) begin
                  cmd_o.last    = 1'b1;
                  cmd_o.led_inc = 1'b1;
                  state_d = S_IDLE;
                end
              end
              default: begin
                cmd_o.sel = SEL_ZERO;
                if (status_i.close) begin
                  cmd_o.last        = 1'b1;
                  cmd_o.clear_frame = 1'b1;
                  state_d = S_IDLE;
                end
              end
            endcase
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= 3'd0;
      id_q     <= 1'b0;
      action_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      id_q     <= id_d;
      action_q <= action_d;
    end
  end

endmodule

// ===== hw/rtl/lfhrp_dp.sv =====
// Datapath of the LED frame report packer: frame state, report length,
// byte selection and the output register. Depends on lfhrp_pkg.
module lfhrp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfhrp_pkg::cmd_t    cmd_i,
  output lfhrp_pkg::status_t status_o,
  input  logic               item_valid_i,
  input  logic               item_action_i,
  input  logic [7:0]         item_red_i,
  input  logic [7:0]         item_green_i,
  input  logic [7:0]         item_blue_i,
  input  logic               cfg_valid_i,
  input  logic [6:0]         cfg_length_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_end_o,
  output logic               out_last_o
);
  import lfhrp_pkg::*;

  logic [6:0] rlen_q;
  logic [5:0] fill_q;
  logic [6:0] led_q;
  logic       hdr_q;
  logic [7:0] red_q, green_q, blue_q;
  logic       ov_q;
  logic [7:0] ob_q;
  logic       oend_q, olast_q;

  logic [6:0] len;
  logic [5:0] plen;
  logic       close;
  logic       out_free;
  logic [7:0] byte_d;

  always_comb begin
    if (rlen_q < RLEN_MIN) begin
      len = RLEN_MIN;
    end else if (rlen_q > RLEN_MAX) begin
      len = RLEN_MAX;
    end else begin
      len = rlen_q;
    end
  end

  assign plen     = 6'(len - 7'd1);
  assign close    = ({1'b0, fill_q} + 7'd1) >= {1'b0, plen};
  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    case (cmd_i.sel)
      SEL_HDR: byte_d = hdr_byte(cmd_i.step);
      SEL_REC: begin
        case (cmd_i.step)
          3'd0:    byte_d = REC_MARK;
          3'd1:    byte_d = {led_q, 1'b1};
          3'd2:    byte_d = red_q;
          3'd3:    byte_d = green_q;
          3'd4:    byte_d = blue_q;
          default: byte_d = 8'h00;
        endcase
      end
      default: byte_d = 8'h00;
    endcase
  end

  assign status_o.item_valid  = item_valid_i;
  assign status_o.item_action = item_action_i;
  assign status_o.hdr_done    = hdr_q;
  assign status_o.fill_zero   = (fill_q == 6'd0);
  assign status_o.close       = close;
  assign status_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlen_q <= RLEN_RESET;
      fill_q <= 6'd0;
      led_q  <= 7'd0;
      hdr_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rlen_q <= cfg_length_i;
      end
      if (cmd_i.push) begin
        fill_q <= close ? 6'd0 : fill_q + 6'd1;
      end
      if (cmd_i.hdr_set) begin
        hdr_q <= 1'b1;
      end
      if (cmd_i.led_inc) begin
        led_q <= led_q + 7'd1;
      end
      if (cmd_i.clear_frame) begin
        led_q <= 7'd0;
        hdr_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      red_q   <= item_red_i;
      green_q <= item_green_i;
      blue_q  <= item_blue_i;
    end
    if (cmd_i.emit) begin
      ob_q    <= byte_d;
      oend_q  <= cmd_i.push && close;
      olast_q <= cmd_i.last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_end_o   = oend_q;
  assign out_last_o  = olast_q;

endmodule

// ===== hw/rtl/led_frame_hid_report_packer.sv =====
// Top level of the LED frame report packer. The first byte of an accepted beat passes through
// the controller state register and then the output register, then one byte per cycle while
// the output is taken. An LED beat yields 5 record bytes plus up to 5 report ID bytes, plus the
// header and its ID bytes on the first LED of a frame. A frame end yields up to 64 bytes.
// Reset clears the frame state and sets report_length to 64.
module led_frame_hid_report_packer (
  input  logic clk_i,
  input  logic rst_ni,
  lfhrp_in_if.sink    item_i,
  lfhrp_out_if.source result_o,
  lfhrp_cfg_if.sink   cfg_i
);
  import lfhrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign item_i.ready = cmd.item_ready;
  assign cfg_i.ready  = 1'b1;

  lfhrp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lfhrp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .item_valid_i  (item_i.valid),
    .item_action_i (item_i.action),
    .item_red_i    (item_i.red),
    .item_green_i  (item_i.green),
    .item_blue_i   (item_i.blue),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_length_i  (cfg_i.report_length),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .out_byte_o    (result_o.out_byte),
    .out_end_o     (result_o.report_end),
    .out_last_o    (result_o.run_last)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("input accepted while an item is in progress");

  a_no_open_report_before_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.ready && !status.hdr_done |-> status.fill_zero)
    else $error("report open before the frame header was sent");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("byte emitted while the output register is held");

endmodule
